/* rtl/adcoc_pkg.sv */
// Shared types, widths and constants of the ADC channel offset calibrator.
// Depends on nothing; every other file of the block uses it.
package adcoc_pkg;

   localparam int CHANNELS    = 24;
   localparam int SAMPLES     = 300;
   localparam int SAMPLE_BITS = 16;

   localparam int CH_W     = 5;
   localparam int RAW_W    = 16;
   localparam int GAIN_W   = 16;
   localparam int CUR_W    = 32;
   localparam int OFF_W    = 20;
   localparam int SUM_W    = 25;
   localparam int CNT_W    = 9;
   localparam int ADDR_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   localparam int X_W          = SUM_W + 5;
   localparam int RECIP_SHIFT  = X_W + CNT_W;
   localparam longint unsigned RECIP =
      ((64'd1 << RECIP_SHIFT) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES);
   localparam int RECIP_W      = $clog2(RECIP + 64'd1);
   localparam int QUOT_W       = X_W + RECIP_W;

   localparam int DIFF_W = ((SAMPLE_BITS + 4 > OFF_W) ? SAMPLE_BITS + 4 : OFF_W) + 1;
   localparam int PROD_W = DIFF_W + GAIN_W;

   localparam int HIST_DEPTH = 3;

   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_CALIBRATE_MODE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN           = 1'd1;

   localparam logic signed [GAIN_W-1:0] GAIN_RESET = 16'shEA16;

   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic [CNT_W-1:0] count;
   } sc_entry_type;

   typedef struct packed {
      logic [CH_W-1:0]         channel_out;
      logic signed [CUR_W-1:0] current;
      logic                    offset_updated;
      logic [OFF_W-1:0]        offset_value;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } push_type;

endpackage

/* rtl/adcoc_if.sv */
// Valid/ready channel interfaces of the ADC channel offset calibrator.
// Depends on adcoc_pkg for the field widths.
interface adcoc_req_if;
   logic                            valid;
   logic                            ready;
   logic [adcoc_pkg::CH_W-1:0]      channel;
   logic [adcoc_pkg::RAW_W-1:0]     raw_sample;

   modport source (output valid, output channel, output raw_sample, input ready);
   modport sink   (input valid, input channel, input raw_sample, output ready);
endinterface

interface adcoc_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [adcoc_pkg::CH_W-1:0]          channel_out;
   logic signed [adcoc_pkg::CUR_W-1:0]  current;
   logic                                offset_updated;
   logic [adcoc_pkg::OFF_W-1:0]         offset_value;

   modport source (output valid, output channel_out, output current,
                   output offset_updated, output offset_value, input ready);
   modport sink   (input valid, input channel_out, input current,
                   input offset_updated, input offset_value, output ready);
endinterface

/* rtl/adcoc_rsp_fifo.sv */
// Result queue that decouples the calculation pipeline from the result channel.
// Depends on adcoc_pkg and adcoc_rsp_if.
module adcoc_rsp_fifo (
   input  logic                             clock,
   input  logic                             reset,
   input  adcoc_pkg::push_type              push,
   output logic [adcoc_pkg::FIFO_CNT_W-1:0] fill,
   adcoc_rsp_if.source                      rsp_chan
);
   import adcoc_pkg::*;

   rsp_type                 entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff;
   logic [FIFO_CNT_W-1:0]   fill_ff;
   logic [FIFO_CNT_W-1:0]   fill_in;
   logic                    pop;
   rsp_type                 head;

   assign pop  = rsp_chan.valid && rsp_chan.ready;
   assign head = entry_ff[rd_ptr_ff];

   assign rsp_chan.valid          = (fill_ff != '0);
   assign rsp_chan.channel_out    = head.channel_out;
   assign rsp_chan.current        = head.current;
   assign rsp_chan.offset_updated = head.offset_updated;
   assign rsp_chan.offset_value   = head.offset_value;
   assign fill                    = fill_ff;

   always_comb begin
      fill_in = fill_ff;
      if (push.valid && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (!push.valid && pop) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         fill_ff <= fill_in;
         if (push.valid) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entry_ff[wr_ptr_ff] <= push.data;
      end
   end

endmodule

/* rtl/adc_channel_offset_calibrator_top.sv */
// Top level of the ADC channel offset calibrator: tables, pipeline and registers.
// Depends on adcoc_pkg, adcoc_if and adcoc_rsp_fifo.
//
// The block takes one tagged sample per clock cycle while its ready is high and
// returns one result for each, in order, through stages 1 to 5 and the result queue.
// The per-channel sums, counts and offsets live in two single-port-read memories with
// registered reads; each sample reads its channel entry at acceptance, the sum and
// count are written in the cycle after and the offset in stage 3, and bypass registers
// cover the writes still in flight so that consecutive samples of one channel see
// each other's updates. A reciprocal multiplication forms the mean and a second
// multiplier applies the gain. Tables read as zero after reset through per-entry
// valid bits, so there is no clearing pass. An eight-entry result queue absorbs
// back-pressure; input is held off while queued plus in-flight results fill the queue.
module adc_channel_offset_calibrator_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [adcoc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [adcoc_pkg::CSR_DATA_W-1:0]   csr_wdata,
   adcoc_req_if.sink                          req_chan,
   adcoc_rsp_if.source                        rsp_chan
);
   import adcoc_pkg::*;

   localparam logic signed [PROD_W:0] SAT_HI = (PROD_W + 1)'(64'sd2147483647);
   localparam logic signed [PROD_W:0] SAT_LO = (PROD_W + 1)'(-64'sd2147483648);

   // Configuration registers.
   logic                     mode_ff;
   logic signed [GAIN_W-1:0] gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         gain_ff <= GAIN_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CALIBRATE_MODE: mode_ff <= csr_wdata[0];
            CSR_GAIN:           gain_ff <= csr_wdata;
         endcase
      end
   end

   // Acceptance and table reads.
   logic                     req_fire;
   logic                     acc_rng;
   logic [ADDR_W-1:0]        acc_addr;
   logic [FIFO_CNT_W-1:0]    fifo_fill;
   logic [2:0]               inflight;

   logic                     s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, s5_v_ff;

   assign inflight = 3'(s1_v_ff) + 3'(s2_v_ff) + 3'(s3_v_ff) + 3'(s4_v_ff) + 3'(s5_v_ff);
   assign req_chan.ready = ((FIFO_CNT_W + 1)'(fifo_fill) + (FIFO_CNT_W + 1)'(inflight))
                           < (FIFO_CNT_W + 1)'(FIFO_DEPTH);
   assign req_fire = req_chan.valid && req_chan.ready;
   assign acc_rng  = int'(req_chan.channel) < CHANNELS;
   assign acc_addr = req_chan.channel[ADDR_W-1:0];

   sc_entry_type             sc_mem [CHANNELS];
   logic [CHANNELS-1:0]      sc_vld_ff;
   sc_entry_type             sc_rd_ff;
   logic                     sc_rd_vld_ff;

   logic [OFF_W-1:0]         off_mem [CHANNELS];
   logic [CHANNELS-1:0]      off_vld_ff;
   logic [OFF_W-1:0]         off_rd_ff;
   logic                     off_rd_vld_ff;

   logic [CH_W-1:0]          s1_ch_ff;
   logic [SAMPLE_BITS-1:0]   s1_raw_ff;
   logic                     s1_rng_ff;

   // Stage 1: sum and count update.
   logic                     sc_h_v_ff;
   logic [CH_W-1:0]          sc_h_ch_ff;
   sc_entry_type             sc_h_val_ff;
   sc_entry_type             sc_old;
   logic [SUM_W-1:0]         sum_inc;
   logic [CNT_W-1:0]         cnt_inc;
   logic                     s1_done;
   logic                     sc_wr;
   sc_entry_type             sc_new;
   logic [X_W-1:0]           s1_x;

   always_comb begin
      if (sc_h_v_ff && (sc_h_ch_ff == s1_ch_ff)) begin
         sc_old = sc_h_val_ff;
      end else if (sc_rd_vld_ff) begin
         sc_old = sc_rd_ff;
      end else begin
         sc_old = '0;
      end
      sum_inc = sc_old.sum + SUM_W'(s1_raw_ff);
      cnt_inc = sc_old.count + 1'b1;
      s1_done = mode_ff && s1_rng_ff && (cnt_inc >= CNT_W'(SAMPLES));
      sc_wr   = s1_v_ff && s1_rng_ff && mode_ff;
      if (s1_done) begin
         sc_new = '0;
      end else begin
         sc_new.sum   = sum_inc;
         sc_new.count = cnt_inc;
      end
      s1_x = X_W'({sum_inc, 4'b0000}) + X_W'(SAMPLES / 2);
   end

   logic [CH_W-1:0]          s2_ch_ff;
   logic [SAMPLE_BITS-1:0]   s2_raw_ff;
   logic                     s2_rng_ff;
   logic                     s2_done_ff;
   logic [X_W-1:0]           s2_x_ff;
   logic [OFF_W-1:0]         s2_off_ff;

   // Stage 2: mean by reciprocal multiplication.
   logic [CH_W-1:0]          s3_ch_ff;
   logic [SAMPLE_BITS-1:0]   s3_raw_ff;
   logic                     s3_rng_ff;
   logic                     s3_done_ff;
   logic [QUOT_W-1:0]        s3_quot_ff;
   logic [OFF_W-1:0]         s3_off_ff;

   // Stage 3: offset resolution, write-back and difference.
   logic                     off_h_v_ff   [HIST_DEPTH];
   logic [CH_W-1:0]          off_h_ch_ff  [HIST_DEPTH];
   logic [OFF_W-1:0]         off_h_val_ff [HIST_DEPTH];
   logic [OFF_W-1:0]         mean;
   logic [OFF_W-1:0]         off_old;
   logic [OFF_W-1:0]         off_cur;
   logic                     off_wr;
   logic signed [DIFF_W-1:0] s3_diff;

   always_comb begin
      mean    = s3_quot_ff[RECIP_SHIFT +: OFF_W];
      off_old = s3_off_ff;
      for (int i = HIST_DEPTH - 1; i >= 0; i--) begin
         if (off_h_v_ff[i] && (off_h_ch_ff[i] == s3_ch_ff)) begin
            off_old = off_h_val_ff[i];
         end
      end
      priority if (!s3_rng_ff) begin
         off_cur = '0;
      end else if (s3_done_ff) begin
         off_cur = mean;
      end else begin
         off_cur = off_old;
      end
      off_wr  = s3_v_ff && s3_rng_ff;
      s3_diff = $signed(DIFF_W'({s3_raw_ff, 4'b0000})) - $signed(DIFF_W'(off_cur));
   end

   logic [CH_W-1:0]          s4_ch_ff;
   logic                     s4_done_ff;
   logic [OFF_W-1:0]         s4_off_ff;
   logic signed [DIFF_W-1:0] s4_diff_ff;

   // Stage 4: gain multiplication.
   logic signed [PROD_W-1:0] s4_prod;
   assign s4_prod = s4_diff_ff * gain_ff;

   logic [CH_W-1:0]          s5_ch_ff;
   logic                     s5_done_ff;
   logic [OFF_W-1:0]         s5_off_ff;
   logic signed [PROD_W-1:0] s5_prod_ff;

   // Stage 5: rounding, saturation and hand-over to the result queue.
   logic signed [PROD_W:0]   rnd;
   logic signed [PROD_W:0]   quo;
   push_type                 push;

   always_comb begin
      rnd = (PROD_W + 1)'(s5_prod_ff) + (PROD_W + 1)'(8);
      quo = rnd >>> 4;
      push.valid               = s5_v_ff;
      push.data.channel_out    = s5_ch_ff;
      push.data.offset_updated = s5_done_ff;
      push.data.offset_value   = s5_off_ff;
      priority if (quo > SAT_HI) begin
         push.data.current = 32'sh7FFFFFFF;
      end else if (quo < SAT_LO) begin
         push.data.current = 32'sh80000000;
      end else begin
         push.data.current = quo[CUR_W-1:0];
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff    <= 1'b0;
         s2_v_ff    <= 1'b0;
         s3_v_ff    <= 1'b0;
         s4_v_ff    <= 1'b0;
         s5_v_ff    <= 1'b0;
         sc_vld_ff  <= '0;
         off_vld_ff <= '0;
         sc_h_v_ff  <= 1'b0;
         for (int i = 0; i < HIST_DEPTH; i++) begin
            off_h_v_ff[i] <= 1'b0;
         end
      end else begin
         s1_v_ff   <= req_fire;
         s2_v_ff   <= s1_v_ff;
         s3_v_ff   <= s2_v_ff;
         s4_v_ff   <= s3_v_ff;
         s5_v_ff   <= s4_v_ff;
         sc_h_v_ff <= sc_wr;
         if (sc_wr) begin
            sc_vld_ff[s1_ch_ff[ADDR_W-1:0]] <= 1'b1;
         end
         if (off_wr) begin
            off_vld_ff[s3_ch_ff[ADDR_W-1:0]] <= 1'b1;
         end
         off_h_v_ff[0] <= off_wr;
         for (int i = 1; i < HIST_DEPTH; i++) begin
            off_h_v_ff[i] <= off_h_v_ff[i-1];
         end
      end
   end

   // Memories and payload registers.
   always_ff @(posedge clock) begin
      if (req_fire && acc_rng) begin
         sc_rd_ff      <= sc_mem[acc_addr];
         sc_rd_vld_ff  <= sc_vld_ff[acc_addr];
         off_rd_ff     <= off_mem[acc_addr];
         off_rd_vld_ff <= off_vld_ff[acc_addr];
      end
      if (sc_wr) begin
         sc_mem[s1_ch_ff[ADDR_W-1:0]] <= sc_new;
      end
      if (off_wr) begin
         off_mem[s3_ch_ff[ADDR_W-1:0]] <= off_cur;
      end

      s1_ch_ff  <= req_chan.channel;
      s1_raw_ff <= req_chan.raw_sample[SAMPLE_BITS-1:0];
      s1_rng_ff <= acc_rng;

      sc_h_ch_ff  <= s1_ch_ff;
      sc_h_val_ff <= sc_new;

      s2_ch_ff   <= s1_ch_ff;
      s2_raw_ff  <= s1_raw_ff;
      s2_rng_ff  <= s1_rng_ff;
      s2_done_ff <= s1_done;
      s2_x_ff    <= s1_x;
      s2_off_ff  <= off_rd_vld_ff ? off_rd_ff : '0;

      s3_ch_ff   <= s2_ch_ff;
      s3_raw_ff  <= s2_raw_ff;
      s3_rng_ff  <= s2_rng_ff;
      s3_done_ff <= s2_done_ff;
      s3_quot_ff <= QUOT_W'(s2_x_ff) * QUOT_W'(RECIP);
      s3_off_ff  <= s2_off_ff;

      off_h_ch_ff[0]  <= s3_ch_ff;
      off_h_val_ff[0] <= off_cur;
      for (int i = 1; i < HIST_DEPTH; i++) begin
         off_h_ch_ff[i]  <= off_h_ch_ff[i-1];
         off_h_val_ff[i] <= off_h_val_ff[i-1];
      end

      s4_ch_ff   <= s3_ch_ff;
      s4_done_ff <= s3_done_ff;
      s4_off_ff  <= off_cur;
      s4_diff_ff <= s3_diff;

      s5_ch_ff   <= s4_ch_ff;
      s5_done_ff <= s4_done_ff;
      s5_off_ff  <= s4_off_ff;
      s5_prod_ff <= s4_prod;
   end

   adcoc_rsp_fifo u_rsp_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .fill     (fifo_fill),
      .rsp_chan (rsp_chan)
   );

endmodule
